// ===== rtl/core/pid_ta_pkg.sv =====
// Shared constants, register indexes and saturation helpers for the PID regulator.
`default_nettype none
package pid_ta_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd7;

    // Saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
        logic ok;
        ok = (&x[33:31]) | ~(|x[33:31]);
        if (ok)
            sat34 = x[31:0];
        else if (x[33])
            sat34 = {1'b1, 31'd0};
        else
            sat34 = {1'b0, {31{1'b1}}};
    endfunction

    // Saturate a 69-bit signed product to 32 bits
    function automatic logic signed [31:0] sat69(input logic signed [68:0] x);
        logic ok;
        ok = (&x[68:31]) | ~(|x[68:31]);
        if (ok)
            sat69 = x[31:0];
        else if (x[68])
            sat69 = {1'b1, 31'd0};
        else
            sat69 = {1'b0, {31{1'b1}}};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pid_trapezoid_antiwindup.sv =====
// Top level of the PID regulator with trapezoidal integral and back-calculation anti-windup.
`default_nettype none
// Signed fixed-point PID regulator (FRAC_BITS fractional bits, Q16.16 by default).
// A compute transaction (mode 0) forms error = target - measured, the derivative
// (error - last error) / step_time through a bit-serial restoring divider, and the
// trapezoidal integral increment, then drive = gain_p*e + gain_i*integral +
// gain_d*derivative, all saturated to 32 bits. With clamp_enable set, drive is
// clamped to [out_min, out_max] (upper limit checked first) and the averaged clamp
// difference, scaled by gain_aw, is fed back into the integral. A restart
// transaction (mode 1) clears the stored state and returns nothing.
// The divider retires one quotient bit per cycle, and one shared shift-add multiplier
// retires one multiplier bit per cycle with a result step after each product (four
// products, five with clamping enabled). A compute transaction holds in_stall from
// its acceptance until its drive is loaded into the output register. Drive appears
// on the edge at which in_stall drops, provided the output register is free;
// otherwise the block holds until it is.
// in_stall stays high while a transaction is in work; the output register lets a
// new transaction in while the previous drive still waits on out_stall.
// Registers are to be written only while the block is idle; the block itself does not enforce this.
module pid_trapezoid_antiwindup #(
    parameter int FRAC_BITS = pid_ta_pkg::FRAC_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration
    input  wire                                   cfg_write,
    input  wire  [pid_ta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [pid_ta_pkg::DATA_W-1:0]         cfg_data,
    // input channel
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   mode,
    input  wire  signed [pid_ta_pkg::DATA_W-1:0]  target,
    input  wire  signed [pid_ta_pkg::DATA_W-1:0]  measured,
    // output channel
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic signed [pid_ta_pkg::DATA_W-1:0]  drive
);

    localparam int DW  = 32 + FRAC_BITS;       // dividend width
    localparam int DCW = $clog2(DW + 1);
    localparam int MW  = 34;                   // multiplier operand width
    localparam int MCW = $clog2(MW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DEND = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_MEND = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [2:0] OP_INC = 3'd0;
    localparam logic [2:0] OP_P   = 3'd1;
    localparam logic [2:0] OP_I   = 3'd2;
    localparam logic [2:0] OP_D   = 3'd3;
    localparam logic [2:0] OP_AW  = 3'd4;

    // configuration registers
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, gain_aw_reg;
    logic signed [31:0] out_min_reg, out_max_reg;
    logic               clamp_en_reg;
    logic [30:0]        step_reg;

    // controller state and work registers
    logic [2:0]         state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] last_err_reg, last_err_next;
    logic signed [31:0] lcd_reg, lcd_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [33:0] sum_reg, sum_next;
    logic signed [31:0] drv_reg, drv_next;
    logic               neg_reg, neg_next;

    // bit-serial divider
    logic [DW-1:0]      num_reg, num_next;
    logic [DW-1:0]      quo_reg, quo_next;
    logic [31:0]        rem_reg, rem_next;
    logic [DCW-1:0]     dcnt_reg, dcnt_next;

    // shift-add multiplier
    logic signed [MW-1:0] mul_a_reg, mul_a_next;
    logic [MW-1:0]        mul_b_reg, mul_b_next;
    logic signed [MW:0]   mul_hi_reg, mul_hi_next;
    logic [MW-1:0]        mul_lo_reg, mul_lo_next;
    logic [MCW-1:0]       mcnt_reg, mcnt_next;

    logic signed [31:0] drive_reg, drive_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_accept;
    logic               out_free;
    logic [30:0]        dt_eff;
    logic signed [31:0] diff_w;
    logic [31:0]        mag_w;
    logic [31:0]        rem_sh;
    logic               rem_ge;
    logic signed [MW-1:0] addend;
    logic signed [MW:0]   hi_sum;
    logic signed [68:0]   prod_w;
    logic signed [68:0]   prod_sh;
    logic signed [31:0]   prod_sat;
    logic signed [31:0]   unc_w;
    logic signed [31:0]   clamp_w;
    logic signed [31:0]   aw_w;
    logic signed [32:0]   avg_sum;
    logic signed [31:0]   avg_w;
    logic                 q_big_pos;
    logic                 q_big_neg;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // A zero step time acts as one LSB
    assign dt_eff = (step_reg == 31'd0) ? 31'd1 : step_reg;

    // Error difference and its magnitude for the divider
    assign diff_w = pid_ta_pkg::sat34({{2{err_reg[31]}}, err_reg}
                                      - {{2{last_err_reg[31]}}, last_err_reg});
    assign mag_w  = diff_w[31] ? (~diff_w + 32'd1) : diff_w;

    // One restoring division step
    assign rem_sh = {rem_reg[30:0], num_reg[DW-1]};
    assign rem_ge = (rem_sh >= {1'b0, dt_eff});

    // Quotient overflow beyond the signed 32-bit range
    assign q_big_pos = (|quo_reg[DW-1:31]);
    assign q_big_neg = (|quo_reg[DW-1:32]) || (quo_reg[31] && (|quo_reg[30:0]));

    // One shift-add step; the sign bit of b is weighted negatively
    assign addend = mul_b_reg[0] ? mul_a_reg : '0;
    assign hi_sum = (mcnt_reg == MCW'(MW - 1))
                  ? mul_hi_reg - {addend[MW-1], addend}
                  : mul_hi_reg + {addend[MW-1], addend};

    // Finished product, floor-shifted and saturated
    assign prod_w   = {mul_hi_reg, mul_lo_reg};
    assign prod_sh  = (op_reg == OP_INC) ? (prod_w >>> (FRAC_BITS + 1))
                                         : (prod_w >>> FRAC_BITS);
    assign prod_sat = pid_ta_pkg::sat69(prod_sh);

    // Output clamp and anti-windup difference (valid once the D term is summed)
    assign unc_w   = pid_ta_pkg::sat34(sum_reg + {{2{prod_sat[31]}}, prod_sat});
    assign clamp_w = (unc_w > out_max_reg) ? out_max_reg
                   : (unc_w < out_min_reg) ? out_min_reg : unc_w;
    assign aw_w    = pid_ta_pkg::sat34({{2{clamp_w[31]}}, clamp_w}
                                       - {{2{unc_w[31]}}, unc_w});
    assign avg_sum = {lcd_reg[31], lcd_reg} + {aw_w[31], aw_w};
    assign avg_w   = avg_sum[32:1];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        err_next       = err_reg;
        last_err_next  = last_err_reg;
        lcd_next       = lcd_reg;
        integ_next     = integ_reg;
        deriv_next     = deriv_reg;
        sum_next       = sum_reg;
        drv_next       = drv_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_hi_next    = mul_hi_reg;
        mul_lo_next    = mul_lo_reg;
        mcnt_next      = mcnt_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode)
                    begin
                        // restart: drop stored state, no result
                        last_err_next = '0;
                        lcd_next      = '0;
                        integ_next    = '0;
                    end
                    else
                    begin
                        err_next   = pid_ta_pkg::sat34({{2{target[31]}}, target}
                                                       - {{2{measured[31]}}, measured});
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                neg_next   = diff_w[31];
                num_next   = {mag_w, {FRAC_BITS{1'b0}}};
                quo_next   = '0;
                rem_next   = '0;
                dcnt_next  = DCW'(DW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next   = rem_ge ? (rem_sh - {1'b0, dt_eff}) : rem_sh;
                quo_next   = {quo_reg[DW-2:0], rem_ge};
                num_next   = {num_reg[DW-2:0], 1'b0};
                dcnt_next  = dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                    state_next = S_DEND;
            end
            S_DEND:
            begin
                // apply sign, saturate, then start (last_err + err) * dt
                if (neg_reg)
                    deriv_next = q_big_neg ? {1'b1, 31'd0} : (~quo_reg[31:0] + 32'd1);
                else
                    deriv_next = q_big_pos ? {1'b0, {31{1'b1}}} : quo_reg[31:0];
                op_next     = OP_INC;
                mul_a_next  = {{2{last_err_reg[31]}}, last_err_reg}
                            + {{2{err_reg[31]}}, err_reg};
                mul_b_next  = {3'b000, dt_eff};
                mul_hi_next = '0;
                mul_lo_next = '0;
                mcnt_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                mul_hi_next = {hi_sum[MW], hi_sum[MW:1]};
                mul_lo_next = {hi_sum[0], mul_lo_reg[MW-1:1]};
                mul_b_next  = {1'b0, mul_b_reg[MW-1:1]};
                mcnt_next   = mcnt_reg + MCW'(1);
                if (mcnt_reg == MCW'(MW - 1))
                    state_next = S_MEND;
            end
            S_MEND:
            begin
                mul_hi_next = '0;
                mul_lo_next = '0;
                mcnt_next   = '0;
                state_next  = S_MUL;
                unique case (op_reg)
                    OP_INC:
                    begin
                        integ_next    = pid_ta_pkg::sat34({{2{integ_reg[31]}}, integ_reg}
                                                          + {{2{prod_sat[31]}}, prod_sat});
                        last_err_next = err_reg;
                        sum_next      = '0;
                        op_next       = OP_P;
                        mul_a_next    = {{2{gain_p_reg[31]}}, gain_p_reg};
                        mul_b_next    = {{2{err_reg[31]}}, err_reg};
                    end
                    OP_P:
                    begin
                        sum_next   = {{2{prod_sat[31]}}, prod_sat};
                        op_next    = OP_I;
                        mul_a_next = {{2{gain_i_reg[31]}}, gain_i_reg};
                        mul_b_next = {{2{integ_reg[31]}}, integ_reg};
                    end
                    OP_I:
                    begin
                        sum_next   = sum_reg + {{2{prod_sat[31]}}, prod_sat};
                        op_next    = OP_D;
                        mul_a_next = {{2{gain_d_reg[31]}}, gain_d_reg};
                        mul_b_next = {{2{deriv_reg[31]}}, deriv_reg};
                    end
                    OP_D:
                    begin
                        if (clamp_en_reg)
                        begin
                            drv_next   = clamp_w;
                            lcd_next   = aw_w;
                            op_next    = OP_AW;
                            mul_a_next = {{2{gain_aw_reg[31]}}, gain_aw_reg};
                            mul_b_next = {{2{avg_w[31]}}, avg_w};
                        end
                        else
                        begin
                            drv_next   = unc_w;
                            state_next = S_OUT;
                        end
                    end
                    OP_AW:
                    begin
                        integ_next = pid_ta_pkg::sat34({{2{integ_reg[31]}}, integ_reg}
                                                       + {{2{prod_sat[31]}}, prod_sat});
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    drive_next     = drv_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            gain_aw_reg   <= '0;
            clamp_en_reg  <= 1'b0;
            out_min_reg   <= {1'b1, 31'd0};
            out_max_reg   <= {1'b0, {31{1'b1}}};
            step_reg      <= 31'(1) << FRAC_BITS;
            state_reg     <= S_IDLE;
            op_reg        <= OP_INC;
            last_err_reg  <= '0;
            lcd_reg       <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            mcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pid_ta_pkg::REG_GAIN_P:    gain_p_reg   <= cfg_data;
                    pid_ta_pkg::REG_GAIN_I:    gain_i_reg   <= cfg_data;
                    pid_ta_pkg::REG_GAIN_D:    gain_d_reg   <= cfg_data;
                    pid_ta_pkg::REG_GAIN_AW:   gain_aw_reg  <= cfg_data;
                    pid_ta_pkg::REG_CLAMP_EN:  clamp_en_reg <= cfg_data[0];
                    pid_ta_pkg::REG_OUT_MIN:   out_min_reg  <= cfg_data;
                    pid_ta_pkg::REG_OUT_MAX:   out_max_reg  <= cfg_data;
                    pid_ta_pkg::REG_STEP_TIME: step_reg     <= cfg_data[30:0];
                    default:                   step_reg     <= step_reg;
                endcase
            end
            state_reg     <= state_next;
            op_reg        <= op_next;
            last_err_reg  <= last_err_next;
            lcd_reg       <= lcd_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
            dcnt_reg      <= dcnt_next;
            mcnt_reg      <= mcnt_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        deriv_reg  <= deriv_next;
        sum_reg    <= sum_next;
        drv_reg    <= drv_next;
        neg_reg    <= neg_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        mul_hi_reg <= mul_hi_next;
        mul_lo_reg <= mul_lo_next;
        drive_reg  <= drive_next;
    end

    // the remainder stays below the divisor through every division step
    a_rem_below_dt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, dt_eff}))
        else $error("divider remainder not below step time");

    // the division counter is never exhausted inside the division loop
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dcnt_reg != '0))
        else $error("division loop ran past its count");

    // only the known products pass through the multiplier
    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_MEND) |-> (op_reg <= OP_AW))
        else $error("multiplier operation out of range");

    // a result waiting at a free output register is presented on the next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not presented");

    // the anti-windup product only runs with clamping enabled
    a_aw_needs_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && op_reg == OP_AW) |-> clamp_en_reg)
        else $error("anti-windup product without clamping");

endmodule
`default_nettype wire

// ===== test/pid_ta_checker.sv =====
// Checker for the PID regulator: tracks the register writes, predicts each drive value and compares.
`timescale 1ns / 1ps
module pid_ta_checker (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_write,
    input  wire  [pid_ta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [pid_ta_pkg::DATA_W-1:0]         cfg_data,
    input  wire                                   in_valid,
    input  wire                                   in_stall,
    input  wire                                   mode,
    input  wire  signed [pid_ta_pkg::DATA_W-1:0]  target,
    input  wire  signed [pid_ta_pkg::DATA_W-1:0]  measured,
    input  wire                                   out_valid,
    input  wire                                   out_stall,
    input  wire  signed [pid_ta_pkg::DATA_W-1:0]  drive,
    output int                                    errors,
    output int                                    pending
);

    localparam int FB = pid_ta_pkg::FRAC_BITS_DEF;

    longint kp, ki, kd, kaw, lo, hi, dt_reg;
    bit     clamp_on;
    longint prev_err, prev_clamp, integ;
    logic [31:0] drive_q[$];

    function automatic longint sat(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fxm(input longint a, input longint b);
        return sat((a * b) >>> FB);
    endfunction

    // Advance the regulator state by one compute transaction, return the drive
    task automatic predict_drive(input logic [31:0] t, input logic [31:0] m,
                                 output logic [31:0] res);
        longint dt, err, dif, der, inc, unc, drv, aw, avg;
        dt  = (dt_reg == 0) ? 1 : dt_reg;
        err = sat(longint'($signed(t)) - longint'($signed(m)));
        dif = sat(err - prev_err);
        der = sat((dif * (64'sd1 << FB)) / dt);
        inc = sat(((prev_err + err) * dt) >>> (FB + 1));
        integ = sat(integ + inc);
        prev_err = err;
        unc = sat(fxm(kp, err) + fxm(ki, integ) + fxm(kd, der));
        drv = unc;
        if (clamp_on) begin
            // upper limit wins when the limits are inverted
            if (drv > hi)
                drv = hi;
            else if (drv < lo)
                drv = lo;
            aw = sat(drv - unc);
            avg = (prev_clamp + aw) >>> 1;
            integ = sat(integ + fxm(kaw, avg));
            prev_clamp = aw;
        end
        res = drv[31:0];
    endtask

    assign pending = drive_q.size();

    always @(posedge clk or negedge rst_n) begin
        logic [31:0] exp_v;
        if (!rst_n) begin
            kp = 0; ki = 0; kd = 0; kaw = 0;
            clamp_on = 0;
            lo = -64'sd2147483648;
            hi = 64'sd2147483647;
            dt_reg = 64'sd1 << FB;
            prev_err = 0; prev_clamp = 0; integ = 0;
            drive_q.delete();
            errors <= 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    pid_ta_pkg::REG_GAIN_P:    kp = longint'($signed(cfg_data));
                    pid_ta_pkg::REG_GAIN_I:    ki = longint'($signed(cfg_data));
                    pid_ta_pkg::REG_GAIN_D:    kd = longint'($signed(cfg_data));
                    pid_ta_pkg::REG_GAIN_AW:   kaw = longint'($signed(cfg_data));
                    pid_ta_pkg::REG_CLAMP_EN:  clamp_on = cfg_data[0];
                    pid_ta_pkg::REG_OUT_MIN:   lo = longint'($signed(cfg_data));
                    pid_ta_pkg::REG_OUT_MAX:   hi = longint'($signed(cfg_data));
                    pid_ta_pkg::REG_STEP_TIME: dt_reg = longint'(cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                if (mode) begin
                    prev_err = 0; prev_clamp = 0; integ = 0;
                end else begin
                    predict_drive(target, measured, exp_v);
                    drive_q.push_back(exp_v);
                end
            end
            if (out_valid && !out_stall) begin
                if (drive_q.size() == 0) begin
                    if (errors < 10)
                        $display("checker: unexpected drive %0d", drive);
                    errors <= errors + 1;
                end else begin
                    exp_v = drive_q.pop_front();
                    if (drive !== exp_v) begin
                        if (errors < 10)
                            $display("checker: drive mismatch, expected %0d got %0d",
                                     $signed(exp_v), drive);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the PID regulator.
`timescale 1ns / 1ps
module tb;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] SMAX = 32'h7fff_ffff;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [pid_ta_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pid_ta_pkg::DATA_W-1:0]    cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic signed [pid_ta_pkg::DATA_W-1:0] target;
    logic signed [pid_ta_pkg::DATA_W-1:0] measured;
    logic        out_valid;
    logic        out_stall;
    logic signed [pid_ta_pkg::DATA_W-1:0] drive;
    int          errors;
    int          pending;

    // percent of cycles the sender idles / the receiver stalls in the current phase
    int          send_idle_pct;
    int          recv_stall_pct;
    // request for a long receiver hold-off, served by the receiver process
    bit          hold_req;

    pid_trapezoid_antiwindup u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .target(target), .measured(measured),
        .out_valid(out_valid), .out_stall(out_stall), .drive(drive)
    );

    pid_ta_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .target(target), .measured(measured),
        .out_valid(out_valid), .out_stall(out_stall), .drive(drive),
        .errors(errors), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #100ms;
        $display("tb: errors");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request so the block backs up
    initial begin
        int hold;
        hold = 0;
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (hold_req && hold == 0)
                hold = 3000;
            if (hold > 0) begin
                hold--;
                if (hold == 0)
                    hold_req = 0;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Write one register; the caller lowers the write enable afterwards
    task automatic reg_write(input logic [pid_ta_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                             input logic [31:0] aw, input logic en, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [31:0] dt);
        reg_write(pid_ta_pkg::REG_GAIN_P, p);
        reg_write(pid_ta_pkg::REG_GAIN_I, i);
        reg_write(pid_ta_pkg::REG_GAIN_D, d);
        reg_write(pid_ta_pkg::REG_GAIN_AW, aw);
        reg_write(pid_ta_pkg::REG_CLAMP_EN, {31'd0, en});
        reg_write(pid_ta_pkg::REG_OUT_MIN, lo);
        reg_write(pid_ta_pkg::REG_OUT_MAX, hi);
        reg_write(pid_ta_pkg::REG_STEP_TIME, dt);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one transaction and hold it until the block takes it
    task automatic send(input logic md, input logic [31:0] t, input logic [31:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= md;
        target   <= t;
        measured <= m;
        // stall is stable at the falling edge; the next rising edge accepts if it is low
        forever begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
    endtask

    // Drop valid, drain every expected drive, then let a trailing restart finish
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(input int kind);
        case (kind)
            0: return SMAX;
            1: return SMIN;
            2: return 32'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_item;
        int r;
        r = $urandom_range(99);
        if (r < 4)
            send(1'b1, $urandom, $urandom);
        else if (r < 14)
            send(1'b0, rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)));
        else if (r < 40)
            send(1'b0, $urandom, $urandom);
        else
            send(1'b0, rand_word(2), rand_word(2));
    endtask

    function automatic logic [31:0] rand_gain;
        case ($urandom_range(5))
            0: return $urandom;
            1: return SMAX;
            2: return SMIN;
            default: return 32'(int'($urandom_range(0, 32'h30000)) - 32'h18000);
        endcase
    endfunction

    initial begin
        int ph;
        logic [31:0] a, b;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        mode = 0;
        target = '0;
        measured = '0;
        hold_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain PID, clamp off, error extremes and restart
        load_regs(ONE, ONE >> 1, ONE >> 2, 32'h0, 1'b0, SMIN, SMAX, ONE);
        send(1'b0, SMAX, SMIN);
        send(1'b0, SMIN, SMAX);
        send(1'b0, 32'h0, 32'h0);
        send(1'b0, SMAX, SMAX);
        send(1'b1, SMAX, SMIN);
        send(1'b0, 32'h0003_0000, 32'h0001_0000);
        send(1'b0, 32'hffff_ffff, 32'h5555_5555);
        drain();

        // Directed: zero step time acts as one LSB, inverted limits, anti-windup on
        load_regs(ONE << 2, ONE, ONE, 32'hffff_8000, 1'b1, 32'h0001_86a0, 32'hfffe_7960, 32'h0);
        send(1'b0, 32'h0010_0000, 32'h0);
        send(1'b0, 32'h0, 32'h0010_0000);
        send(1'b0, 32'h0001_0000, 32'h0001_0000);
        send(1'b1, 32'h0, 32'h0);
        send(1'b0, 32'haaaa_aaaa, 32'h0);
        drain();

        // Directed: gain and step extremes, clamping to the full range and then to [-1.0, 1.0]
        load_regs(SMIN, SMAX, SMIN, SMAX, 1'b1, SMIN, SMAX, SMAX);
        send(1'b0, SMAX, SMIN);
        send(1'b0, SMIN, SMAX);
        send(1'b0, 32'h1, 32'h0);
        send(1'b0, SMIN, SMIN);
        drain();
        load_regs(SMAX, SMIN, SMAX, SMIN, 1'b1, 32'hffff_0000, 32'h0001_0000, 32'h1);
        send(1'b0, SMAX, SMIN);
        send(1'b0, 32'h0, SMAX);
        send(1'b0, 32'h7, 32'h3);
        drain();

        // Random phases: new registers each time and an idling pattern that cycles through four settings
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            a = 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            b = a + $urandom_range(0, 32'h0010_0000);
            if (ph == 6) begin
                a = SMAX;
                b = SMIN;
            end
            load_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                      1'(ph % 3 != 0), a, b,
                      (ph == 5) ? 32'h0 : (ph == 7) ? SMAX
                                : {1'b0, 31'($urandom_range(1, 32'h0004_0000))});
            if (ph == 2)
                hold_req = 1;
            repeat (175) rand_item();
            drain();
        end

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
